// ===== hdl/yuyv_pair_to_rgb_top_macros.svh =====
// Assertion macros used by the top module of the YUYV pair to RGB converter.
`ifndef YUYV_PAIR_TO_RGB_TOP_MACROS_SVH
`define YUYV_PAIR_TO_RGB_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YP2R_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yp2r assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define YP2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yp2r assertion failed");

`endif

// ===== hdl/yp2r_pkg.sv =====
// Package with types, widths and register codes of the YUYV pair to RGB converter.
`timescale 1ns / 1ps

package yp2r_pkg;

    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 12;
    localparam int KNEE_W  = 8;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 12;
    // Signed gain (13 bits) times signed offset (9 bits).
    localparam int PROD_W  = GAIN_W + 1 + PIX_W + 1;
    // Up to three products are summed; two guard bits cover the growth.
    localparam int SUM_W   = PROD_W + 2;

    localparam logic [IDX_W-1:0] REG_LUMA_GAIN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_BLUE_FROM_U  = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN_FROM_V = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_FROM_U = 3'd3;
    localparam logic [IDX_W-1:0] REG_RED_FROM_V   = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLIP_KNEE    = 3'd5;

    localparam logic [GAIN_W-1:0] RST_LUMA_GAIN    = 12'd1192;
    localparam logic [GAIN_W-1:0] RST_BLUE_FROM_U  = 12'd2066;
    localparam logic [GAIN_W-1:0] RST_GREEN_FROM_V = 12'd833;
    localparam logic [GAIN_W-1:0] RST_GREEN_FROM_U = 12'd403;
    localparam logic [GAIN_W-1:0] RST_RED_FROM_V   = 12'd1634;
    localparam logic [KNEE_W-1:0] RST_CLIP_KNEE    = 8'd250;

    localparam logic signed [PIX_W:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [PIX_W:0] CHROMA_OFFSET = 9'sd128;

    typedef struct packed {
        logic [GAIN_W-1:0] luma_gain;
        logic [GAIN_W-1:0] blue_from_u;
        logic [GAIN_W-1:0] green_from_v;
        logic [GAIN_W-1:0] green_from_u;
        logic [GAIN_W-1:0] red_from_v;
        logic [KNEE_W-1:0] clip_knee;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] y_first;
        logic [PIX_W-1:0] u_shared;
        logic [PIX_W-1:0] y_second;
        logic [PIX_W-1:0] v_shared;
        logic             last_pair;
    } pair_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] luma_first;
        logic signed [PROD_W-1:0] luma_second;
        logic signed [PROD_W-1:0] red_v;
        logic signed [PROD_W-1:0] green_v;
        logic signed [PROD_W-1:0] green_u;
        logic signed [PROD_W-1:0] blue_u;
        logic                     last_pair;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] red_first;
        logic signed [SUM_W-1:0] green_first;
        logic signed [SUM_W-1:0] blue_first;
        logic signed [SUM_W-1:0] red_second;
        logic signed [SUM_W-1:0] green_second;
        logic signed [SUM_W-1:0] blue_second;
        logic                    last_pair;
    } sum_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] red_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] blue_second;
        logic             last_pair;
    } rgb_t;

endpackage

// ===== hdl/yp2r_in_if.sv =====
// Input channel carrying one YUYV macropixel word.
`timescale 1ns / 1ps

interface yp2r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] y_first;
    logic [7:0] u_shared;
    logic [7:0] y_second;
    logic [7:0] v_shared;
    logic       last_pair;

    modport source (output valid, y_first, u_shared, y_second, v_shared, last_pair,
                    input ready);
    modport sink (input valid, y_first, u_shared, y_second, v_shared, last_pair,
                  output ready);
endinterface

// ===== hdl/yp2r_out_if.sv =====
// Output channel carrying one word of two RGB888 pixels.
`timescale 1ns / 1ps

interface yp2r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       last_pair_out;

    modport source (output valid, red_first, green_first, blue_first, red_second,
                    green_second, blue_second, last_pair_out, input ready);
    modport sink (input valid, red_first, green_first, blue_first, red_second,
                  green_second, blue_second, last_pair_out, output ready);
endinterface

// ===== hdl/yuyv_pair_to_rgb_top.sv =====
// An accepted word passes the product, sum and saturation registers in turn before it shows on the output.
// Throughput: one macropixel word per cycle while the output takes words; the three stage
// registers (products, sums, saturation) each hold one word, and a stall at the output
// backs up stage by stage without losing or repeating a word.
// Reset clears the stage valid bits and restores the gain and knee registers.
`timescale 1ns / 1ps

`include "yuyv_pair_to_rgb_top_macros.svh"

module yuyv_pair_to_rgb_top #(
    parameter int FRAC_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    yp2r_in_if.sink                     in_pair,
    yp2r_out_if.source                  out_pair,
    input  logic                        cfg_write_en,
    input  logic [yp2r_pkg::IDX_W-1:0]  cfg_index,
    input  logic [yp2r_pkg::DATA_W-1:0] cfg_data
);
    import yp2r_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    pair_t in_word;
    logic  s1_valid;
    logic  s1_ready;
    prod_t s1_data;
    logic  s2_valid;
    logic  s2_ready;
    sum_t  s2_data;
    logic  s3_ready;
    rgb_t  s3_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_LUMA_GAIN:    cfg_next.luma_gain    = cfg_data[GAIN_W-1:0];
                REG_BLUE_FROM_U:  cfg_next.blue_from_u  = cfg_data[GAIN_W-1:0];
                REG_GREEN_FROM_V: cfg_next.green_from_v = cfg_data[GAIN_W-1:0];
                REG_GREEN_FROM_U: cfg_next.green_from_u = cfg_data[GAIN_W-1:0];
                REG_RED_FROM_V:   cfg_next.red_from_v   = cfg_data[GAIN_W-1:0];
                REG_CLIP_KNEE:    cfg_next.clip_knee    = cfg_data[KNEE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.luma_gain    <= RST_LUMA_GAIN;
            cfg_reg.blue_from_u  <= RST_BLUE_FROM_U;
            cfg_reg.green_from_v <= RST_GREEN_FROM_V;
            cfg_reg.green_from_u <= RST_GREEN_FROM_U;
            cfg_reg.red_from_v   <= RST_RED_FROM_V;
            cfg_reg.clip_knee    <= RST_CLIP_KNEE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_word.y_first   = in_pair.y_first;
    assign in_word.u_shared  = in_pair.u_shared;
    assign in_word.y_second  = in_pair.y_second;
    assign in_word.v_shared  = in_pair.v_shared;
    assign in_word.last_pair = in_pair.last_pair;

    yp2r_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_pair.valid),
        .in_ready  (in_pair.ready),
        .in_data   (in_word),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    yp2r_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    yp2r_clamp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .clip_knee (cfg_reg.clip_knee),
        .in_valid  (s2_valid),
        .in_ready  (s3_ready),
        .in_data   (s2_data),
        .out_valid (out_pair.valid),
        .out_ready (out_pair.ready),
        .out_data  (s3_data)
    );

    assign s2_ready               = s3_ready;
    assign out_pair.red_first     = s3_data.red_first;
    assign out_pair.green_first   = s3_data.green_first;
    assign out_pair.blue_first    = s3_data.blue_first;
    assign out_pair.red_second    = s3_data.red_second;
    assign out_pair.green_second  = s3_data.green_second;
    assign out_pair.blue_second   = s3_data.blue_second;
    assign out_pair.last_pair_out = s3_data.last_pair;

    // A full pipeline behind a stalled output must refuse new words.
    `YP2R_ASSERT_NOW(a_full_blocks_input, clk, rst_n,
        s1_valid && s2_valid && out_pair.valid && !out_pair.ready, !in_pair.ready)
    // An empty first stage always has room.
    `YP2R_ASSERT_NOW(a_empty_takes_input, clk, rst_n, !s1_valid, in_pair.ready)
    // A sum word that cannot move on stays in its stage.
    `YP2R_ASSERT_NEXT(a_sum_holds, clk, rst_n, s2_valid && !s3_ready, s2_valid)

endmodule

// ===== hdl/yp2r_mult.sv =====
// First pipeline stage: offset removal and the six gain products.
`timescale 1ns / 1ps

module yp2r_mult (
    input  logic           clk,
    input  logic           rst_n,
    input  yp2r_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  yp2r_pkg::pair_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output yp2r_pkg::prod_t out_data
);
    import yp2r_pkg::*;

    logic                     valid_reg;
    prod_t                    data_reg;
    prod_t                    data_next;
    logic signed [PIX_W:0]    y1_off;
    logic signed [PIX_W:0]    y2_off;
    logic signed [PIX_W:0]    du;
    logic signed [PIX_W:0]    dv;
    logic signed [GAIN_W:0]   g_luma;
    logic signed [GAIN_W:0]   g_red_v;
    logic signed [GAIN_W:0]   g_green_v;
    logic signed [GAIN_W:0]   g_green_u;
    logic signed [GAIN_W:0]   g_blue_u;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        y1_off    = $signed({1'b0, in_data.y_first}) - LUMA_OFFSET;
        y2_off    = $signed({1'b0, in_data.y_second}) - LUMA_OFFSET;
        du        = $signed({1'b0, in_data.u_shared}) - CHROMA_OFFSET;
        dv        = $signed({1'b0, in_data.v_shared}) - CHROMA_OFFSET;
        g_luma    = $signed({1'b0, cfg.luma_gain});
        g_red_v   = $signed({1'b0, cfg.red_from_v});
        g_green_v = $signed({1'b0, cfg.green_from_v});
        g_green_u = $signed({1'b0, cfg.green_from_u});
        g_blue_u  = $signed({1'b0, cfg.blue_from_u});

        data_next.luma_first  = g_luma * y1_off;
        data_next.luma_second = g_luma * y2_off;
        data_next.red_v       = g_red_v * dv;
        data_next.green_v     = g_green_v * dv;
        data_next.green_u     = g_green_u * du;
        data_next.blue_u      = g_blue_u * du;
        data_next.last_pair   = in_data.last_pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hdl/yp2r_sum.sv =====
// Second pipeline stage: the three channel sums of both pixels.
`timescale 1ns / 1ps

module yp2r_sum (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  yp2r_pkg::prod_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output yp2r_pkg::sum_t  out_data
);
    import yp2r_pkg::*;

    logic                    valid_reg;
    sum_t                    data_reg;
    sum_t                    data_next;
    logic signed [SUM_W-1:0] l1;
    logic signed [SUM_W-1:0] l2;
    logic signed [SUM_W-1:0] rv;
    logic signed [SUM_W-1:0] gv;
    logic signed [SUM_W-1:0] gu;
    logic signed [SUM_W-1:0] bu;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        l1 = SUM_W'(in_data.luma_first);
        l2 = SUM_W'(in_data.luma_second);
        rv = SUM_W'(in_data.red_v);
        gv = SUM_W'(in_data.green_v);
        gu = SUM_W'(in_data.green_u);
        bu = SUM_W'(in_data.blue_u);

        data_next.red_first    = l1 + rv;
        data_next.green_first  = l1 - gv - gu;
        data_next.blue_first   = l1 + bu;
        data_next.red_second   = l2 + rv;
        data_next.green_second = l2 - gv - gu;
        data_next.blue_second  = l2 + bu;
        data_next.last_pair    = in_data.last_pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hdl/yp2r_clamp.sv =====
// Third pipeline stage: saturation of each sum to an 8-bit channel, and the output register.
`timescale 1ns / 1ps

module yp2r_clamp #(
    parameter int FRAC_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [yp2r_pkg::KNEE_W-1:0] clip_knee,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  yp2r_pkg::sum_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output yp2r_pkg::rgb_t               out_data
);
    import yp2r_pkg::*;

    // The compare width holds the shifted knee with a clear sign bit.
    localparam int KNEE_CMP_W = KNEE_W + FRAC_BITS + 1;
    localparam int CMP_W      = (KNEE_CMP_W > SUM_W) ? KNEE_CMP_W : SUM_W;

    logic             valid_reg;
    rgb_t             data_reg;
    rgb_t             data_next;
    logic [CMP_W-1:0] knee_scaled;

    function automatic logic [PIX_W-1:0] clamp_channel(
        input logic signed [SUM_W-1:0] sum,
        input logic [CMP_W-1:0]        knee
    );
        logic signed [CMP_W-1:0] sum_ext;
        logic [PIX_W-1:0]        chan;
        sum_ext = CMP_W'(sum);
        if (sum_ext > $signed(knee))
        begin
            chan = {PIX_W{1'b1}};
        end
        else if (sum < 0)
        begin
            chan = '0;
        end
        else
        begin
            chan = sum[FRAC_BITS+PIX_W-1:FRAC_BITS];
        end
        return chan;
    endfunction

    assign knee_scaled = CMP_W'(clip_knee) << FRAC_BITS;
    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_data    = data_reg;

    always_comb
    begin
        data_next.red_first    = clamp_channel(in_data.red_first, knee_scaled);
        data_next.green_first  = clamp_channel(in_data.green_first, knee_scaled);
        data_next.blue_first   = clamp_channel(in_data.blue_first, knee_scaled);
        data_next.red_second   = clamp_channel(in_data.red_second, knee_scaled);
        data_next.green_second = clamp_channel(in_data.green_second, knee_scaled);
        data_next.blue_second  = clamp_channel(in_data.blue_second, knee_scaled);
        data_next.last_pair    = in_data.last_pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
